/* design/mmp_pkg.sv */
package mmp_pkg;

  // Store holds BUFFER_DEPTH-1 payload bytes.
  localparam int BUFFER_DEPTH = 16;
  localparam int STORE_DEPTH  = BUFFER_DEPTH - 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH);
  localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [CNT_W-1:0] STORE_FULL = CNT_W'(STORE_DEPTH);

  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END   = 8'hF7;

  localparam logic [3:0] TYPE_PROG  = 4'hC;
  localparam logic [3:0] TYPE_PRESS = 4'hD;

  // d / 12 == (d * 171) >> 11 for every 7-bit d
  localparam logic [14:0] NOTE_RECIP = 15'd171;
  localparam int          NOTE_SHIFT = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPLAY
  } mmp_state_e;

endpackage

/* design/midi_message_parser_unit.sv */
// MIDI byte parser with a system exclusive capture memory.
// Each input beat is accepted in ST_IDLE, then handled by one read-modify-write
// step in ST_EXEC, which repeats while the output register is held; a channel
// result is registered from ST_EXEC. An end of sysex or a full store holds off input
// while the memory (one read port, registered read data) replays the stored bytes.
// Reset (rst_ni low, asynchronous) clears parser and output valid state.
module midi_message_parser_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              is_sysex_o,
  output logic [3:0]        msg_type_o,
  output logic [3:0]        channel_o,
  output logic [6:0]        first_data_o,
  output logic [6:0]        second_data_o,
  output logic signed [13:0] bend_value_o,
  output logic [3:0]        note_class_o,
  output logic signed [4:0] note_octave_o,
  output logic [7:0]        sysex_byte_o,
  output logic              sysex_empty_o,
  output logic              truncated_o,
  output logic              last_o
);
  import mmp_pkg::*;

  mmp_state_e        state_q, state_d;
  logic [7:0]        byte_q;
  logic              in_sysex_q, in_sysex_d;
  logic              have_status_q, have_status_d;
  logic              done_q, done_d;
  logic [7:0]        status_q, status_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [6:0]        held_q, held_d;
  logic              trunc_q, trunc_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic [7:0]        store_mem [STORE_DEPTH];
  logic [7:0]        rd_data_q;
  logic              wr_en;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              is_sysex_q, is_sysex_d;
  logic [3:0]        msg_type_q, msg_type_d;
  logic [3:0]        channel_q, channel_d;
  logic [6:0]        first_q, first_d;
  logic [6:0]        second_q, second_d;
  logic [13:0]       bend_q, bend_d;
  logic [3:0]        class_q, class_d;
  logic [4:0]        octave_q, octave_d;
  logic [7:0]        sx_byte_q, sx_byte_d;
  logic              sx_empty_q, sx_empty_d;
  logic              trunc_out_q, trunc_out_d;
  logic              last_q, last_d;

  logic              slot_free;
  logic [6:0]        ch_d1, ch_d2;
  logic [14:0]       note_prod;
  logic [3:0]        note_quot;
  logic [6:0]        note_rem;
  logic [3:0]        byte_type;
  logic              rep_last;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign byte_type = status_q[7:4];
  assign rep_last  = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));

  // channel message payload; a one-data-byte message carries its byte first
  assign ch_d1 = (cnt_q == '0) ? byte_q[6:0] : held_q;
  assign ch_d2 = (cnt_q == '0) ? 7'd0 : byte_q[6:0];

  assign note_prod = 15'(ch_d1) * NOTE_RECIP;
  assign note_quot = note_prod[NOTE_SHIFT +: 4];
  assign note_rem  = ch_d1 - 7'(note_quot) * 7'd12;

  always_comb begin
    state_d       = state_q;
    in_sysex_d    = in_sysex_q;
    have_status_d = have_status_q;
    done_d        = done_q;
    status_d      = status_q;
    cnt_d         = cnt_q;
    held_d        = held_q;
    trunc_d       = trunc_q;
    idx_d         = idx_q;
    wr_en         = 1'b0;

    out_valid_d = out_valid_q && out_stall_i;
    is_sysex_d  = is_sysex_q;
    msg_type_d  = msg_type_q;
    channel_d   = channel_q;
    first_d     = first_q;
    second_d    = second_q;
    bend_d      = bend_q;
    class_d     = class_q;
    octave_d    = octave_q;
    sx_byte_d   = sx_byte_q;
    sx_empty_d  = sx_empty_q;
    trunc_out_d = trunc_out_q;
    last_d      = last_q;

    in_stall_o = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        if (byte_q == SYX_START) begin
          in_sysex_d    = 1'b1;
          have_status_d = 1'b0;
          done_d        = 1'b0;
          cnt_d         = '0;
        end else if (in_sysex_q) begin
          if (byte_q == SYX_END || cnt_q >= STORE_FULL) begin
            if (cnt_q == '0) begin
              // empty payload: single marker result
              if (slot_free) begin
                in_sysex_d  = 1'b0;
                out_valid_d = 1'b1;
                is_sysex_d  = 1'b1;
                msg_type_d  = '0;
                channel_d   = '0;
                first_d     = '0;
                second_d    = '0;
                bend_d      = '0;
                class_d     = '0;
                octave_d    = '0;
                sx_byte_d   = '0;
                sx_empty_d  = 1'b1;
                trunc_out_d = (byte_q != SYX_END);
                last_d      = 1'b1;
              end else begin
                state_d = ST_EXEC;
              end
            end else begin
              in_sysex_d = 1'b0;
              trunc_d    = (byte_q != SYX_END);
              idx_d      = '0;
              state_d    = ST_REPLAY;
            end
          end else begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end else if (byte_q[7]) begin
          status_d      = byte_q;
          have_status_d = 1'b1;
          done_d        = 1'b0;
          cnt_d         = '0;
        end else if (have_status_q && !done_q) begin
          if (cnt_q == '0 && byte_type != TYPE_PROG && byte_type != TYPE_PRESS) begin
            held_d = byte_q[6:0];
            cnt_d  = CNT_W'(1);
          end else begin
            if (slot_free) begin
              done_d      = 1'b1;
              if (cnt_q != '0) begin
                cnt_d = CNT_W'(2);
              end
              out_valid_d = 1'b1;
              is_sysex_d  = 1'b0;
              msg_type_d  = status_q[7:4];
              channel_d   = status_q[3:0];
              first_d     = ch_d1;
              second_d    = ch_d2;
              bend_d      = {~ch_d2[6], ch_d2[5:0], ch_d1};  // minus 8192 mod 2^14
              class_d     = note_rem[3:0];
              octave_d    = 5'(note_quot) - 5'd1;
              sx_byte_d   = '0;
              sx_empty_d  = 1'b0;
              trunc_out_d = 1'b0;
              last_d      = 1'b1;
            end else begin
              state_d = ST_EXEC;
            end
          end
        end
      end

      ST_REPLAY: begin
        // rd_data_q holds entry idx_q
        if (slot_free) begin
          out_valid_d = 1'b1;
          is_sysex_d  = 1'b1;
          msg_type_d  = '0;
          channel_d   = '0;
          first_d     = '0;
          second_d    = '0;
          bend_d      = '0;
          class_d     = '0;
          octave_d    = '0;
          sx_byte_d   = rd_data_q;
          sx_empty_d  = 1'b0;
          trunc_out_d = trunc_q;
          last_d      = rep_last;
          if (rep_last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + ADDR_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      in_sysex_q    <= 1'b0;
      have_status_q <= 1'b0;
      done_q        <= 1'b0;
      status_q      <= '0;
      cnt_q         <= '0;
      held_q        <= '0;
      trunc_q       <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      in_sysex_q    <= in_sysex_d;
      have_status_q <= have_status_d;
      done_q        <= done_d;
      status_q      <= status_d;
      cnt_q         <= cnt_d;
      held_q        <= held_d;
      trunc_q       <= trunc_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
    is_sysex_q  <= is_sysex_d;
    msg_type_q  <= msg_type_d;
    channel_q   <= channel_d;
    first_q     <= first_d;
    second_q    <= second_d;
    bend_q      <= bend_d;
    class_q     <= class_d;
    octave_q    <= octave_d;
    sx_byte_q   <= sx_byte_d;
    sx_empty_q  <= sx_empty_d;
    trunc_out_q <= trunc_out_d;
    last_q      <= last_d;
  end

  // capture writes and replay reads never fall in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[cnt_q[ADDR_W-1:0]] <= byte_q;
    end
    rd_data_q <= store_mem[idx_d];
  end

  assign out_valid_o   = out_valid_q;
  assign is_sysex_o    = is_sysex_q;
  assign msg_type_o    = msg_type_q;
  assign channel_o     = channel_q;
  assign first_data_o  = first_q;
  assign second_data_o = second_q;
  assign bend_value_o  = bend_q;
  assign note_class_o  = class_q;
  assign note_octave_o = octave_q;
  assign sysex_byte_o  = sx_byte_q;
  assign sysex_empty_o = sx_empty_q;
  assign truncated_o   = trunc_out_q;
  assign last_o        = last_q;

endmodule
